### rtl/core/lorenz_euler_integrator_macros.svh
// Assertion macros for the Lorenz Euler integrator.
`ifndef LORENZ_EULER_INTEGRATOR_MACROS_SVH
`define LORENZ_EULER_INTEGRATOR_MACROS_SVH

`ifndef SYNTHESIS
`define LEI_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define LEI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LEI_ASSERT_IMPL(lbl, ante, cons, msg)
`define LEI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/lei_pkg.sv
// Shared types and constants for the Lorenz Euler integrator.
package lei_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned DT_W    = 31;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned MUL_A_W = COORD_W + 1;
	localparam int unsigned MUL_B_W = COORD_W;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [MUL_A_W-1:0] mul_a_t;
	typedef logic [CIDX_W-1:0]         cfg_idx_t;

	localparam cfg_idx_t REG_SIGMA   = 3'd0;
	localparam cfg_idx_t REG_BETA    = 3'd1;
	localparam cfg_idx_t REG_RHO     = 3'd2;
	localparam cfg_idx_t REG_DT      = 3'd3;
	localparam cfg_idx_t REG_START_X = 3'd4;
	localparam cfg_idx_t REG_START_Y = 3'd5;
	localparam cfg_idx_t REG_START_Z = 3'd6;

	localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
	localparam coord_t COORD_MIN = 32'sh8000_0000;

endpackage

### rtl/core/lorenz_euler_integrator.sv
// Lorenz attractor forward Euler stepper on one shared multiplier.
// The run does one multiply per cycle, from input transfer to result valid.
// A new item is taken only once the last has left the run state, after its seven products through one multiplier.
// The last step stalls while an earlier result waits on the output register.
// Reset (arst_n low, asynchronous): registers load sigma 10, beta 2.666, rho 28,
// dt 0.001, start point (1,1,1); coordinates load (1,1,1); both channels go idle.
`include "lorenz_euler_integrator_macros.svh"

module lorenz_euler_integrator #(
	parameter int FRAC_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [lei_pkg::CIDX_W-1:0]          cfg_idx,
	input  logic [lei_pkg::COORD_W-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lei_pkg::COORD_W-1:0]  next_x,
	output logic signed [lei_pkg::COORD_W-1:0]  next_y,
	output logic signed [lei_pkg::COORD_W-1:0]  next_z,
	output logic                                clamped
);

	localparam int RES_W = lei_pkg::PROD_W - FRAC_BITS;
	localparam int SUM_W = RES_W + 2;
	localparam int CW    = lei_pkg::COORD_W;

	localparam logic [CW-1:0] RST_SIGMA = CW'(64'd10 << FRAC_BITS);
	localparam logic [CW-1:0] RST_BETA  = CW'(((64'd2666 << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [CW-1:0] RST_RHO   = CW'(64'd28 << FRAC_BITS);
	localparam logic [CW-1:0] RST_ONE   = CW'(64'd1 << FRAC_BITS);
	localparam logic [lei_pkg::DT_W-1:0] RST_DT =
		lei_pkg::DT_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

	typedef enum logic {S_IDLE, S_RUN} state_t;
	typedef enum logic [2:0] {
		ST_XY, ST_BZ, ST_SIG, ST_RHO, ST_DTZ, ST_DTX, ST_DTY, ST_DONE
	} step_t;

	state_t state_q;
	step_t  cnt_q;
	step_t  post_step;
	logic   out_valid_q;
	logic   flag_q;

	lei_pkg::coord_t sigma_q, beta_q, rho_q;
	logic [lei_pkg::DT_W-1:0] dt_q;
	lei_pkg::coord_t sx_q, sy_q, sz_q;
	lei_pkg::coord_t pos_x_q, pos_y_q, pos_z_q;

	lei_pkg::mul_a_t dxy_q, drz_q;
	logic signed [lei_pkg::PROD_W-1:0] prod_q;
	logic signed [RES_W-1:0] t_q;
	lei_pkg::coord_t dx_q, dy_q, dz_q;
	lei_pkg::coord_t out_x_q, out_y_q, out_z_q;
	logic clamped_q;

	lei_pkg::mul_a_t ma;
	lei_pkg::coord_t mb;
	logic signed [lei_pkg::PROD_W-1:0] prod;
	logic signed [RES_W-1:0] r;
	logic signed [SUM_W-1:0] add_a, add_b, sum;
	logic add_sub;
	logic ovf;
	lei_pkg::coord_t sat;
	logic step_go;
	logic in_xfer;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign next_x    = out_x_q;
	assign next_y    = out_y_q;
	assign next_z    = out_z_q;
	assign clamped   = clamped_q;

	assign step_go   = (state_q == S_RUN) &&
		((cnt_q != ST_DONE) || !out_valid_q || out_ready);
	assign post_step = step_t'(cnt_q - 3'd1);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cnt_q)
			ST_XY: begin
				ma = lei_pkg::MUL_A_W'(pos_x_q);
				mb = pos_y_q;
			end
			ST_BZ: begin
				ma = lei_pkg::MUL_A_W'(pos_z_q);
				mb = beta_q;
			end
			ST_SIG: begin
				ma = dxy_q;
				mb = sigma_q;
			end
			ST_RHO: begin
				ma = drz_q;
				mb = pos_x_q;
			end
			ST_DTZ: begin
				ma = {2'b00, dt_q};
				mb = dz_q;
			end
			ST_DTX: begin
				ma = {2'b00, dt_q};
				mb = dx_q;
			end
			ST_DTY: begin
				ma = {2'b00, dt_q};
				mb = dy_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod = lei_pkg::PROD_W'(ma) * lei_pkg::PROD_W'(mb);
	assign r    = RES_W'(prod_q >>> FRAC_BITS);

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (post_step)
			ST_XY: begin
				add_b = SUM_W'(r);
			end
			ST_BZ: begin
				add_a   = SUM_W'(t_q);
				add_b   = SUM_W'(r);
				add_sub = 1'b1;
			end
			ST_SIG: begin
				add_b = SUM_W'(r);
			end
			ST_RHO: begin
				add_a   = SUM_W'(r);
				add_b   = SUM_W'(pos_y_q);
				add_sub = 1'b1;
			end
			ST_DTZ: begin
				add_a = SUM_W'(pos_z_q);
				add_b = SUM_W'(r);
			end
			ST_DTX: begin
				add_a = SUM_W'(pos_x_q);
				add_b = SUM_W'(r);
			end
			ST_DTY: begin
				add_a = SUM_W'(pos_y_q);
				add_b = SUM_W'(r);
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign sum = add_a + (add_sub ? -add_b : add_b);
	assign ovf = !((&sum[SUM_W-1:CW-1]) || !(|sum[SUM_W-1:CW-1]));
	assign sat = ovf ? (sum[SUM_W-1] ? lei_pkg::COORD_MIN : lei_pkg::COORD_MAX)
		: sum[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= ST_XY;
			out_valid_q <= 1'b0;
			flag_q      <= 1'b0;
			sigma_q     <= RST_SIGMA;
			beta_q      <= RST_BETA;
			rho_q       <= RST_RHO;
			dt_q        <= RST_DT;
			sx_q        <= RST_ONE;
			sy_q        <= RST_ONE;
			sz_q        <= RST_ONE;
			pos_x_q     <= RST_ONE;
			pos_y_q     <= RST_ONE;
			pos_z_q     <= RST_ONE;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					lei_pkg::REG_SIGMA:   sigma_q <= cfg_wdata;
					lei_pkg::REG_BETA:    beta_q  <= cfg_wdata;
					lei_pkg::REG_RHO:     rho_q   <= cfg_wdata;
					lei_pkg::REG_DT:      dt_q    <= cfg_wdata[lei_pkg::DT_W-1:0];
					lei_pkg::REG_START_X: sx_q    <= cfg_wdata;
					lei_pkg::REG_START_Y: sy_q    <= cfg_wdata;
					lei_pkg::REG_START_Z: sz_q    <= cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && !(step_go && cnt_q == ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_RUN;
						cnt_q   <= ST_XY;
						flag_q  <= 1'b0;
						if (restart) begin
							pos_x_q <= sx_q;
							pos_y_q <= sy_q;
							pos_z_q <= sz_q;
						end
					end
				end
				S_RUN: begin
					if (step_go) begin
						if (post_step != ST_XY && post_step != ST_DONE) begin
							flag_q <= flag_q | ovf;
						end
						case (post_step)
							ST_DTZ: pos_z_q <= sat;
							ST_DTX: pos_x_q <= sat;
							ST_DTY: pos_y_q <= sat;
							default: ;
						endcase
						if (cnt_q == ST_DONE) begin
							state_q     <= S_IDLE;
							out_valid_q <= 1'b1;
						end else begin
							cnt_q <= step_t'(cnt_q + 3'd1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			prod_q <= prod;
			if (cnt_q == ST_XY) begin
				dxy_q <= lei_pkg::MUL_A_W'(pos_y_q) - lei_pkg::MUL_A_W'(pos_x_q);
				drz_q <= lei_pkg::MUL_A_W'(rho_q) - lei_pkg::MUL_A_W'(pos_z_q);
			end
			case (post_step)
				ST_XY:  t_q  <= RES_W'(sum);
				ST_BZ:  dz_q <= sat;
				ST_SIG: dx_q <= sat;
				ST_RHO: dy_q <= sat;
				default: ;
			endcase
			if (cnt_q == ST_DONE) begin
				out_x_q   <= pos_x_q;
				out_y_q   <= sat;
				out_z_q   <= pos_z_q;
				clamped_q <= flag_q | ovf;
			end
		end
	end

	`LEI_ASSERT_NEXT(a_xfer_starts_run, in_xfer, state_q == S_RUN && cnt_q == ST_XY, "run did not start after input transfer")
	`LEI_ASSERT_NEXT(a_step_advance, state_q == S_RUN && cnt_q != ST_DONE, cnt_q == step_t'($past(cnt_q) + 3'd1), "sequencer skipped a step")
	`LEI_ASSERT_IMPL(a_result_from_done, $rose(out_valid_q), $past(state_q == S_RUN && cnt_q == ST_DONE), "result raised outside final step")

endmodule

### test/tb_lorenz_euler_integrator.sv
// Self-checking testbench for the Lorenz Euler integrator: directed, back-pressure and random runs.
module tb_lorenz_euler_integrator;

	localparam int FRAC_BITS = 24;
	localparam int CLK_PERIOD = 8;
	localparam int PIPE_LAT = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam lei_pkg::cfg_idx_t REG_UNUSED = 3'd7;
	localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

	typedef struct packed {
		lei_pkg::coord_t x;
		lei_pkg::coord_t y;
		lei_pkg::coord_t z;
		logic   clamped;
	} step_result_t;

	typedef struct packed {
		logic [31:0] sigma;
		logic [31:0] beta;
		logic [31:0] rho;
		logic [31:0] dt;
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] sz;
	} reg_set_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	lei_pkg::cfg_idx_t cfg_idx;
	logic [lei_pkg::COORD_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic restart;
	logic out_valid;
	logic out_ready;
	logic signed [lei_pkg::COORD_W-1:0] next_x;
	logic signed [lei_pkg::COORD_W-1:0] next_y;
	logic signed [lei_pkg::COORD_W-1:0] next_z;
	logic clamped;

	lei_pkg::coord_t k_sigma, k_beta, k_rho, org_x, org_y, org_z;
	lei_pkg::coord_t cur_x, cur_y, cur_z;
	logic [lei_pkg::DT_W-1:0] k_dt;

	step_result_t results_due[$];
	step_result_t want;
	int unsigned mismatches = 0;
	int unsigned tx_idle_pct = 29;
	int unsigned rx_idle_pct = 83;
	int unsigned hold_left = 0;
	bit hold_req = 1'b0;
	int unsigned idle_run = 0;

	lorenz_euler_integrator #(.FRAC_BITS(FRAC_BITS)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_x   (next_x),
		.next_y   (next_y),
		.next_z   (next_z),
		.clamped  (clamped)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint fit32(input longint v);
		if (v > longint'(lei_pkg::COORD_MAX))
			return longint'(lei_pkg::COORD_MAX);
		if (v < longint'(lei_pkg::COORD_MIN))
			return longint'(lei_pkg::COORD_MIN);
		return v;
	endfunction

	function automatic step_result_t lorenz_step(input logic rst);
		longint x, y, z, sg, bt, rh, dt, t, dx, dy, dz, nx, ny, nz;
		logic hit;
		step_result_t res;
		if (rst) begin
			cur_x = org_x;
			cur_y = org_y;
			cur_z = org_z;
		end
		x = cur_x;
		y = cur_y;
		z = cur_z;
		sg = k_sigma;
		bt = k_beta;
		rh = k_rho;
		dt = k_dt;
		t = (sg * (y - x)) >>> FRAC_BITS;
		dx = fit32(t);
		hit = (dx != t);
		t = ((x * (rh - z)) >>> FRAC_BITS) - y;
		dy = fit32(t);
		hit |= (dy != t);
		t = ((x * y) >>> FRAC_BITS) - ((bt * z) >>> FRAC_BITS);
		dz = fit32(t);
		hit |= (dz != t);
		t = x + ((dt * dx) >>> FRAC_BITS);
		nx = fit32(t);
		hit |= (nx != t);
		t = y + ((dt * dy) >>> FRAC_BITS);
		ny = fit32(t);
		hit |= (ny != t);
		t = z + ((dt * dz) >>> FRAC_BITS);
		nz = fit32(t);
		hit |= (nz != t);
		cur_x = nx[31:0];
		cur_y = ny[31:0];
		cur_z = nz[31:0];
		res.x = cur_x;
		res.y = cur_y;
		res.z = cur_z;
		res.clamped = hit;
		return res;
	endfunction

	function automatic logic [31:0] near_or_wild(input logic [31:0] nominal,
			input int unsigned spread);
		if ($urandom_range(3) == 0)
			return $urandom;
		return nominal + $urandom_range(spread) - spread / 2;
	endfunction

	function automatic reg_set_t random_regs();
		reg_set_t r;
		r.sigma = near_or_wild(10 * ONE, 8 * ONE);
		r.beta = near_or_wild(3 * ONE, 2 * ONE);
		r.rho = near_or_wild(28 * ONE, 16 * ONE);
		r.dt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(ONE / 64);
		r.sx = near_or_wild(32'd0, 40 * ONE);
		r.sy = near_or_wild(32'd0, 40 * ONE);
		r.sz = near_or_wild(20 * ONE, 40 * ONE);
		return r;
	endfunction

	task automatic write_reg(input lei_pkg::cfg_idx_t idx, input logic [31:0] data);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			lei_pkg::REG_SIGMA:   k_sigma = data;
			lei_pkg::REG_BETA:    k_beta = data;
			lei_pkg::REG_RHO:     k_rho = data;
			lei_pkg::REG_DT:      k_dt = data[lei_pkg::DT_W-1:0];
			lei_pkg::REG_START_X: org_x = data;
			lei_pkg::REG_START_Y: org_y = data;
			lei_pkg::REG_START_Z: org_z = data;
			default: ;
		endcase
	endtask

	task automatic load_regs(input reg_set_t r);
		write_reg(lei_pkg::REG_SIGMA, r.sigma);
		write_reg(lei_pkg::REG_BETA, r.beta);
		write_reg(lei_pkg::REG_RHO, r.rho);
		write_reg(lei_pkg::REG_DT, r.dt);
		write_reg(lei_pkg::REG_START_X, r.sx);
		write_reg(lei_pkg::REG_START_Y, r.sy);
		write_reg(lei_pkg::REG_START_Z, r.sz);
		write_reg(REG_UNUSED, $urandom);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_tick(input logic rst);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		results_due.push_back(lorenz_step(rst));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// result checker and receiver throttle
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: x %h y %h z %h clamped %b",
						next_x, next_y, next_z, clamped);
			end else begin
				want = results_due.pop_front();
				if (want.x !== next_x || want.y !== next_y || want.z !== next_z ||
						want.clamped !== clamped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x %h y %h z %h c %b, got x %h y %h z %h c %b",
							want.x, want.y, want.z, want.clamped,
							next_x, next_y, next_z, clamped);
				end
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic test_reset_state();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drained();
	endtask

	task automatic test_saturation_extremes();
		reg_set_t r;
		r = '{sigma: lei_pkg::COORD_MAX, beta: lei_pkg::COORD_MIN,
			rho: lei_pkg::COORD_MAX, dt: 32'hFFFF_FFFF,
			sx: lei_pkg::COORD_MAX, sy: lei_pkg::COORD_MIN, sz: lei_pkg::COORD_MIN};
		load_regs(r);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_drained();
		r = '{sigma: lei_pkg::COORD_MIN, beta: lei_pkg::COORD_MAX,
			rho: lei_pkg::COORD_MIN, dt: 32'd0,
			sx: lei_pkg::COORD_MIN, sy: lei_pkg::COORD_MAX, sz: lei_pkg::COORD_MAX};
		load_regs(r);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_drained();
		r = '{sigma: 32'd0, beta: 32'd0, rho: 32'd0, dt: ONE,
			sx: 32'd0, sy: 32'd0, sz: 32'd0};
		load_regs(r);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drained();
		// drive single-LSB values, with rho at one, to exercise rounding toward minus infinity
		r = '{sigma: 32'd1, beta: 32'hFFFF_FFFF, rho: ONE, dt: 32'd1,
			sx: 32'hFFFF_FFFF, sy: 32'd1, sz: 32'hFFFF_FFFF};
		load_regs(r);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		wait_drained();
		r = '{sigma: 10 * ONE, beta: 32'd44728058, rho: 28 * ONE, dt: 32'h7FFF_FFFF,
			sx: ONE, sy: ONE, sz: ONE};
		load_regs(r);
		send_tick(1'b1);
		send_tick(1'b0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_regs(random_regs());
		hold_req = 1'b1;
		repeat (40) send_tick($urandom_range(15) == 0);
		wait_drained();
		repeat (10) send_tick($urandom_range(15) == 0);
		wait_drained();
		repeat (10) send_tick($urandom_range(15) == 0);
		wait_drained();
	endtask

	task automatic test_random_orbits(input int unsigned tx_pct, input int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (5) begin
			wait_drained();
			load_regs(random_regs());
			send_tick($urandom_range(1) != 0);
			repeat (124) send_tick($urandom_range(24) == 0);
		end
		wait_drained();
	endtask

	initial begin
		k_sigma = 10 * ONE;
		k_beta = 32'(((64'd2666 << FRAC_BITS) + 64'd500) / 64'd1000);
		k_rho = 28 * ONE;
		k_dt = lei_pkg::DT_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
		org_x = ONE;
		org_y = ONE;
		org_z = ONE;
		cur_x = ONE;
		cur_y = ONE;
		cur_z = ONE;
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_idx <= lei_pkg::REG_SIGMA;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		restart <= 1'b0;
		out_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_saturation_extremes();
		test_backpressure();
		test_random_orbits(29, 83);
		test_random_orbits(83, 29);
		test_random_orbits(0, 0);
		wait_drained();
		if (mismatches == 0 && results_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### lorenz_euler_integrator.f
+incdir+rtl/core
rtl/core/lei_pkg.sv
rtl/core/lorenz_euler_integrator.sv
test/tb_lorenz_euler_integrator.sv
